### hdl/accel_tap_and_orientation_detector_macros.svh
// assertion helpers for the tap and orientation detector
`ifndef ACCEL_TAP_AND_ORIENTATION_DETECTOR_MACROS_SVH
`define ACCEL_TAP_AND_ORIENTATION_DETECTOR_MACROS_SVH

// condition must never hold once out of reset
`define ATOD_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ATOD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define ATOD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hdl/atod_pkg.sv
package atod_pkg;

	localparam int WINDOW_SAMPLES = 8;
	localparam int AW = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
	localparam int CNT_MAX = (WINDOW_SAMPLES + 1 > 16) ? WINDOW_SAMPLES + 1 : 16;
	localparam int CNT_W = $clog2(CNT_MAX + 1);

	localparam logic [17:0] COEF_A = 18'd55771;
	localparam logic [17:0] COEF_B = 18'd34406;
	localparam logic signed [17:0] CLAMP_LIM = 18'sd10240;

	localparam logic [2:0] REG_REQUIRED_DIFF = 3'd0;
	localparam logic [2:0] REG_STATIONARY_DIFF = 3'd1;
	localparam logic [2:0] REG_TAP_WAIT_MS = 3'd2;
	localparam logic [2:0] REG_TAP_LOCKOUT_MS = 3'd3;
	localparam logic [2:0] REG_FACE_COS_SQ = 3'd4;

	localparam logic [2:0] FACE_PX = 3'd0;
	localparam logic [2:0] FACE_PY = 3'd1;
	localparam logic [2:0] FACE_NX = 3'd2;
	localparam logic [2:0] FACE_NY = 3'd3;
	localparam logic [2:0] FACE_PZ = 3'd4;
	localparam logic [2:0] FACE_NZ = 3'd5;

	localparam logic [1:0] IND_NONE = 2'd0;
	localparam logic [1:0] IND_SINGLE = 2'd1;
	localparam logic [1:0] IND_DOUBLE = 2'd2;

	function automatic logic signed [14:0] clamp_g(input logic signed [17:0] v);
		logic signed [17:0] r;
		r = v;
		if (v > CLAMP_LIM) begin
			r = CLAMP_LIM;
		end else if (v < -CLAMP_LIM) begin
			r = -CLAMP_LIM;
		end
		return r[14:0];
	endfunction

	function automatic logic [15:0] absdiff(input logic [15:0] a, input logic [15:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

### hdl/atod_ram.sv
module atod_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/accel_tap_and_orientation_detector.sv
// Tap and orientation detector for a three-axis accelerometer.
// Input channel (in_valid / in_ready): one sample per beat, accel_x/y/z in
// 1/1024 g and a millisecond timestamp now_ms. Output channel (out_valid /
// out_ready): one result beat per sample with face, the held tap_indicator
// and a one-beat double_tap flag.
// From acceptance to out_valid a sample passes 3 squares on the shared
// multiplier, 16 square-root iterations, a write and a one-entry-per-cycle
// scan of the magnitude ring memory, 4 rotation products, 3 smoothed squares
// and one threshold product. in_ready is high only while the sequencer is
// idle, so a new sample is taken on the cycle after the result is registered.
// The result sits in an output register; a stalled receiver holds it and a
// finished sample waits in its last step until the register is free.
// Reset clears all tracking state and loads the register defaults; ring
// entries not yet written read as zero through per-entry valid flags.
// Registers sit on an APB-style port at 4*index; pready is tied high.
module accel_tap_and_orientation_detector (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         face,
	output logic [1:0]         tap_indicator,
	output logic               double_tap
);

	import atod_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MAG = 4'd1;
	localparam logic [3:0] ST_SQRT = 4'd2;
	localparam logic [3:0] ST_WR = 4'd3;
	localparam logic [3:0] ST_SCAN = 4'd4;
	localparam logic [3:0] ST_TAP = 4'd5;
	localparam logic [3:0] ST_ROT = 4'd6;
	localparam logic [3:0] ST_SMOOTH = 4'd7;
	localparam logic [3:0] ST_FSQ = 4'd8;
	localparam logic [3:0] ST_FM = 4'd9;
	localparam logic [3:0] ST_FACE = 4'd10;
	localparam logic [3:0] ST_DONE = 4'd11;

	logic [3:0] state_q;
	logic [CNT_W-1:0] cnt_q;

	logic [15:0] required_diff_q, stationary_diff_q, tap_wait_q, tap_lockout_q, face_cos_sq_q;

	logic signed [15:0] x_q, y_q, z_q;
	logic [31:0] now_q;

	logic signed [30:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [48:0] prod;
	logic signed [33:0] acc_q;
	logic signed [33:0] acc_sum;

	logic [31:0] n_q, res_q, bit_q, sq_sum, res_next;
	logic [15:0] mag_q, maxd_q, old_q, entry, ent_diff;

	logic [AW-1:0] ptr_q, nxt_ptr, rd_idx_q, ram_raddr;
	logic rd_pend_q;
	logic [WINDOW_SAMPLES-1:0] ring_valid_q;
	logic ram_we;
	logic [15:0] ram_rdata;

	logic [1:0] tap_count_q, indicator_q, tc_next, ind_next;
	logic [31:0] last_tap_q, elapsed;
	logic hit, dbl_next, dbl_q;

	logic signed [17:0] rx_q;
	logic signed [14:0] smooth_x_q, smooth_y_q, smooth_z_q;
	logic signed [14:0] rxc, ryc, rzc;
	logic signed [15:0] sum_x, sum_y, sum_z;
	logic [27:0] sqx_q, sqy_q, sqz_q;
	logic [29:0] m2;
	logic [45:0] fm_q;
	logic pass_x, pass_y, pass_z;
	logic [2:0] face_q;

	logic cfg_wr;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			required_diff_q <= 16'd1024;
			stationary_diff_q <= 16'd256;
			tap_wait_q <= 16'd500;
			tap_lockout_q <= 16'd100;
			face_cos_sq_q <= 16'd58254;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_REQUIRED_DIFF: required_diff_q <= pwdata[15:0];
				REG_STATIONARY_DIFF: stationary_diff_q <= pwdata[15:0];
				REG_TAP_WAIT_MS: tap_wait_q <= pwdata[15:0];
				REG_TAP_LOCKOUT_MS: tap_lockout_q <= pwdata[15:0];
				REG_FACE_COS_SQ: face_cos_sq_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_REQUIRED_DIFF: prdata = {16'd0, required_diff_q};
			REG_STATIONARY_DIFF: prdata = {16'd0, stationary_diff_q};
			REG_TAP_WAIT_MS: prdata = {16'd0, tap_wait_q};
			REG_TAP_LOCKOUT_MS: prdata = {16'd0, tap_lockout_q};
			REG_FACE_COS_SQ: prdata = {16'd0, face_cos_sq_q};
			default: prdata = 32'd0;
		endcase
	end

	// shared multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MAG: begin
				case (cnt_q[1:0])
					2'd0: begin
						mul_a = {{15{x_q[15]}}, x_q};
						mul_b = {{2{x_q[15]}}, x_q};
					end
					2'd1: begin
						mul_a = {{15{y_q[15]}}, y_q};
						mul_b = {{2{y_q[15]}}, y_q};
					end
					default: begin
						mul_a = {{15{z_q[15]}}, z_q};
						mul_b = {{2{z_q[15]}}, z_q};
					end
				endcase
			end
			ST_ROT: begin
				case (cnt_q[1:0])
					2'd0: begin
						mul_a = {{15{x_q[15]}}, x_q};
						mul_b = COEF_A;
					end
					2'd1: begin
						mul_a = {{15{y_q[15]}}, y_q};
						mul_b = COEF_B;
					end
					2'd2: begin
						mul_a = {{15{y_q[15]}}, y_q};
						mul_b = COEF_A;
					end
					default: begin
						mul_a = {{15{x_q[15]}}, x_q};
						mul_b = COEF_B;
					end
				endcase
			end
			ST_FSQ: begin
				case (cnt_q[1:0])
					2'd0: begin
						mul_a = {{16{smooth_x_q[14]}}, smooth_x_q};
						mul_b = {{3{smooth_x_q[14]}}, smooth_x_q};
					end
					2'd1: begin
						mul_a = {{16{smooth_y_q[14]}}, smooth_y_q};
						mul_b = {{3{smooth_y_q[14]}}, smooth_y_q};
					end
					default: begin
						mul_a = {{16{smooth_z_q[14]}}, smooth_z_q};
						mul_b = {{3{smooth_z_q[14]}}, smooth_z_q};
					end
				endcase
			end
			ST_FM: begin
				mul_a = {1'b0, m2};
				mul_b = {2'b00, face_cos_sq_q};
			end
			default: ;
		endcase
	end

	assign prod = mul_a * mul_b;
	assign acc_sum = acc_q + $signed(prod[33:0]);

	// square root step
	assign sq_sum = res_q + bit_q;
	assign res_next = (n_q >= sq_sum) ? ((res_q >> 1) + bit_q) : (res_q >> 1);

	// magnitude ring
	assign nxt_ptr = (ptr_q == AW'(WINDOW_SAMPLES - 1)) ? '0 : ptr_q + 1'b1;
	assign ram_we = (state_q == ST_WR);
	assign ram_raddr = cnt_q[AW-1:0];

	atod_ram #(
		.WIDTH(16),
		.DEPTH(WINDOW_SAMPLES)
	) u_ring (
		.clk(clk),
		.we(ram_we),
		.waddr(ptr_q),
		.wdata(mag_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign entry = ring_valid_q[rd_idx_q] ? ram_rdata : 16'd0;
	assign ent_diff = absdiff(entry, mag_q);

	// tap decision
	always_comb begin
		elapsed = now_q - last_tap_q;
		tc_next = (elapsed > {16'd0, tap_wait_q}) ? 2'd0 : tap_count_q;
		hit = 1'b0;
		ind_next = indicator_q;
		dbl_next = 1'b0;
		if (elapsed > {16'd0, tap_lockout_q}) begin
			if (maxd_q > required_diff_q && absdiff(old_q, mag_q) < stationary_diff_q) begin
				hit = 1'b1;
				tc_next = tc_next + 2'd1;
			end
			if (tc_next == 2'd2) begin
				ind_next = IND_DOUBLE;
				tc_next = 2'd0;
				dbl_next = 1'b1;
			end else if (tc_next == 2'd1) begin
				ind_next = IND_SINGLE;
			end else begin
				ind_next = IND_NONE;
			end
		end
	end

	// rotation, clamp and smoothing
	assign rxc = clamp_g(rx_q);
	assign ryc = clamp_g($signed(acc_q[33:16]));
	assign rzc = clamp_g({{2{z_q[15]}}, z_q});
	assign sum_x = {smooth_x_q[14], smooth_x_q} + {rxc[14], rxc};
	assign sum_y = {smooth_y_q[14], smooth_y_q} + {ryc[14], ryc};
	assign sum_z = {smooth_z_q[14], smooth_z_q} + {rzc[14], rzc};

	// face test
	assign m2 = {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};
	assign pass_x = (smooth_x_q != '0) && ({2'b00, sqx_q, 16'd0} > fm_q);
	assign pass_y = (smooth_y_q != '0) && ({2'b00, sqy_q, 16'd0} > fm_q);
	assign pass_z = (smooth_z_q != '0) && ({2'b00, sqz_q, 16'd0} > fm_q);

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			ptr_q <= '0;
			ring_valid_q <= '0;
			rd_pend_q <= 1'b0;
			tap_count_q <= 2'd0;
			indicator_q <= IND_NONE;
			last_tap_q <= 32'd0;
			smooth_x_q <= '0;
			smooth_y_q <= '0;
			smooth_z_q <= '0;
			face_q <= FACE_PX;
			dbl_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MAG;
						cnt_q <= '0;
					end
				end
				ST_MAG: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(2)) begin
						state_q <= ST_SQRT;
						cnt_q <= '0;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(15)) begin
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					ring_valid_q[ptr_q] <= 1'b1;
					rd_pend_q <= 1'b0;
					cnt_q <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					rd_pend_q <= (cnt_q < CNT_W'(WINDOW_SAMPLES));
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(WINDOW_SAMPLES)) begin
						state_q <= ST_TAP;
					end
				end
				ST_TAP: begin
					tap_count_q <= tc_next;
					indicator_q <= ind_next;
					dbl_q <= dbl_next;
					if (hit) begin
						last_tap_q <= now_q;
					end
					ptr_q <= nxt_ptr;
					cnt_q <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(3)) begin
						state_q <= ST_SMOOTH;
					end
				end
				ST_SMOOTH: begin
					smooth_x_q <= sum_x[15:1];
					smooth_y_q <= sum_y[15:1];
					smooth_z_q <= sum_z[15:1];
					cnt_q <= '0;
					state_q <= ST_FSQ;
				end
				ST_FSQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(2)) begin
						state_q <= ST_FM;
					end
				end
				ST_FM: begin
					state_q <= ST_FACE;
				end
				ST_FACE: begin
					if (pass_x) begin
						face_q <= smooth_x_q[14] ? FACE_NX : FACE_PX;
					end else if (pass_y) begin
						face_q <= smooth_y_q[14] ? FACE_NY : FACE_PY;
					end else if (pass_z) begin
						face_q <= smooth_z_q[14] ? FACE_NZ : FACE_PZ;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					x_q <= accel_x;
					y_q <= accel_y;
					z_q <= accel_z;
					now_q <= now_ms;
					acc_q <= '0;
				end
			end
			ST_MAG: begin
				acc_q <= acc_sum;
				if (cnt_q == CNT_W'(2)) begin
					n_q <= acc_sum[31:0];
					res_q <= 32'd0;
					bit_q <= 32'h4000_0000;
				end
			end
			ST_SQRT: begin
				if (n_q >= sq_sum) begin
					n_q <= n_q - sq_sum;
				end
				res_q <= res_next;
				bit_q <= bit_q >> 2;
				if (cnt_q == CNT_W'(15)) begin
					mag_q <= res_next[15:0];
				end
			end
			ST_WR: begin
				maxd_q <= 16'd0;
				old_q <= 16'd0;
			end
			ST_SCAN: begin
				rd_idx_q <= ram_raddr;
				if (rd_pend_q) begin
					if (ent_diff > maxd_q) begin
						maxd_q <= ent_diff;
					end
					if (rd_idx_q == nxt_ptr) begin
						old_q <= entry;
					end
				end
			end
			ST_TAP: begin
				acc_q <= 34'sd32768;
			end
			ST_ROT: begin
				case (cnt_q[1:0])
					2'd0: acc_q <= acc_sum;
					2'd1: acc_q <= acc_q - $signed(prod[33:0]);
					2'd2: begin
						rx_q <= $signed(acc_q[33:16]);
						acc_q <= 34'sd32768 + $signed(prod[33:0]);
					end
					default: acc_q <= acc_sum;
				endcase
			end
			ST_FSQ: begin
				case (cnt_q[1:0])
					2'd0: sqx_q <= prod[27:0];
					2'd1: sqy_q <= prod[27:0];
					default: sqz_q <= prod[27:0];
				endcase
			end
			ST_FM: begin
				fm_q <= prod[45:0];
			end
			ST_DONE: begin
				if (!out_valid || out_ready) begin
					face <= face_q;
					tap_indicator <= indicator_q;
					double_tap <= dbl_q;
				end
			end
			default: ;
		endcase
	end

	`include "accel_tap_and_orientation_detector_macros.svh"

	`ATOD_ASSERT_NEVER(a_tap_count_settled, tap_count_q[1], "stored tap count above one")
	`ATOD_ASSERT_NEVER(a_indicator_code, indicator_q == 2'd3, "tap indicator holds an unused code")
	`ATOD_ASSERT_SAME(a_double_ind, out_valid && double_tap, tap_indicator == IND_DOUBLE, "double tap beat without double indicator")
	`ATOD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "sequencer ready again right after accepting a sample")

endmodule
